[rtl/vertex_dedup_hash_table_defines.svh]
// assertion macros shared by the table logic
// each use expects clk and arst_n in the enclosing module
`ifndef VERTEX_DEDUP_HASH_TABLE_DEFINES_SVH
`define VERTEX_DEDUP_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define VDHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VDHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/vdht_pkg.sv]
package vdht_pkg;

	// table geometry
	localparam int unsigned MAX_ENTRIES = 4096;
	localparam int unsigned BUCKETS     = 4096;
	localparam int unsigned ENTRY_W     = $clog2(MAX_ENTRIES);
	localparam int unsigned LINK_W      = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned BUCKET_W    = $clog2(BUCKETS);

	// field widths
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned VERTEX_W = 11;
	localparam int unsigned INDEX_W  = 12;

	// queue between front and back
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// hash mixing constants
	localparam logic [WORD_W-1:0] HASH_T_MUL  = 32'h85EB_CA6B;
	localparam logic [WORD_W-1:0] HASH_V_MUL  = 32'hC2B2_AE35;
	localparam logic [WORD_W-1:0] HASH_M1_MUL = 32'h7FEB_352D;
	localparam logic [WORD_W-1:0] HASH_M2_MUL = 32'h846C_A68B;

	typedef logic [LINK_W-1:0]   link_t;
	typedef logic [BUCKET_W-1:0] bucket_t;

	typedef struct packed {
		logic [WORD_W-1:0]   s;
		logic [WORD_W-1:0]   t;
		logic [VERTEX_W-1:0] v;
	} key_t;

	// one queued lookup
	typedef struct packed {
		key_t    key;
		bucket_t bucket;
	} q_item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
	} q_status_t;

	// one stored entry: key and chain link
	typedef struct packed {
		key_t  key;
		link_t next;
	} entry_t;

endpackage

[rtl/vertex_dedup_hash_table.sv]
// vertex de-duplication table: gives every distinct corner key a dense index
//
// item channel: item_valid/item_ready with tex_s_bits, tex_t_bits and
// vertex_number; the key is compared as raw bits
// result channel: result_valid/result_ready with unique_index, is_new and
// table_full; exactly one result per item, in item order
//
// a hash front of three multiplier stages feeds an eight-deep queue; the back
// engine pops one key at a time, reads the bucket head, walks the chain one
// entry per cycle and appends on a miss unless the table is full
// path: the three front stages, the queue, then the back engine states idle,
// head, walk (once per chain entry visited) and done
// lookups do not overlap: the back engine pops the next key only after the last
// result is loaded, and the chain walk uses the single read port step by step
// reset: the bucket heads are swept to empty one after another; up to eight
// items are taken and wait until the sweep ends; the entry count returns to zero
// receiver stall: the result register holds; the back engine finishes the
// next lookup and waits, the queue fills and then item_ready drops
module vertex_dedup_hash_table import vdht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [WORD_W-1:0]   tex_s_bits,
	input  logic [WORD_W-1:0]   tex_t_bits,
	input  logic [VERTEX_W-1:0] vertex_number,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [INDEX_W-1:0]  unique_index,
	output logic                is_new,
	output logic                table_full
);

	q_status_t qstat;
	q_item_t   push_item, head_item;
	logic      push, pop;

	// hash and admission
	vdht_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.tex_s_bits   (tex_s_bits),
		.tex_t_bits   (tex_t_bits),
		.vertex_number(vertex_number),
		.qstat        (qstat),
		.push         (push),
		.push_item    (push_item)
	);

	// decoupling queue
	vdht_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head_item(head_item),
		.qstat    (qstat)
	);

	// table engine
	vdht_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head_item   (head_item),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.unique_index(unique_index),
		.is_new      (is_new),
		.table_full  (table_full)
	);

endmodule

[rtl/vdht_front.sv]
module vdht_front import vdht_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [WORD_W-1:0]   tex_s_bits,
	input  logic [WORD_W-1:0]   tex_t_bits,
	input  logic [VERTEX_W-1:0] vertex_number,
	input  q_status_t           qstat,
	output logic                push,
	output q_item_t             push_item
);

	logic              v_s1, v_s2, v_s3;
	key_t              key_s1, key_s2, key_s3;
	logic [WORD_W-1:0] m1_s1, m2_s1, p_s2, p_s3;
	logic [WORD_W-1:0] h2, h3, h4;
	logic [QCNT_W:0]   occ;
	logic              accept;

	// room check: queue plus items still hashing
	always_comb begin
		occ = {1'b0, qstat.count} + (QCNT_W + 1)'(v_s1) + (QCNT_W + 1)'(v_s2)
			+ (QCNT_W + 1)'(v_s3);
		item_ready = (occ < (QCNT_W + 1)'(QDEPTH));
		accept = item_valid && item_ready;
	end

	// mixing steps between the multiplier stages
	always_comb begin
		h2 = key_s1.s ^ m1_s1 ^ m2_s1;
		h2 = h2 ^ (h2 >> 16);
		h3 = p_s2 ^ (p_s2 >> 15);
		h4 = p_s3 ^ (p_s3 >> 16);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// hash pipeline payload
	always_ff @(posedge clk) begin
		key_s1 <= '{s: tex_s_bits, t: tex_t_bits, v: vertex_number};
		m1_s1  <= tex_t_bits * HASH_T_MUL;
		m2_s1  <= WORD_W'(vertex_number) * HASH_V_MUL;
		key_s2 <= key_s1;
		p_s2   <= h2 * HASH_M1_MUL;
		key_s3 <= key_s2;
		p_s3   <= h3 * HASH_M2_MUL;
	end

	// bucket is the low hash bits
	assign push      = v_s3;
	assign push_item = '{key: key_s3, bucket: h4[BUCKET_W-1:0]};

endmodule

[rtl/vdht_fifo.sv]
`include "vertex_dedup_hash_table_defines.svh"

module vdht_fifo import vdht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_item_t   push_item,
	input  logic      pop,
	output q_item_t   head_item,
	output q_status_t qstat
);

	q_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	assign head_item   = mem_q[rd_q];
	assign qstat.count = count_q;
	assign qstat.empty = (count_q == '0);

	`VDHT_ASSERT_IMP(a_no_overflow, push, (count_q != QCNT_W'(QDEPTH)) || pop, "queue overflow")
	`VDHT_ASSERT_IMP(a_no_underflow, pop, count_q != '0, "queue underflow")

endmodule

[rtl/vdht_back.sv]
`include "vertex_dedup_hash_table_defines.svh"

module vdht_back import vdht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  q_status_t          qstat,
	input  q_item_t            head_item,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [INDEX_W-1:0] unique_index,
	output logic               is_new,
	output logic               table_full
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [BUCKET_W-1:0] clr_q;
	link_t              count_q;
	key_t               key_q;
	bucket_t            bucket_q;
	link_t              head_link_q;
	link_t              link_q;
	logic [INDEX_W-1:0] res_idx_q;
	logic               res_new_q, res_full_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic               out_new_q, out_full_q;

	// table memories
	link_t  head_mem [BUCKETS];
	entry_t entry_mem [MAX_ENTRIES];
	link_t  head_rd_q;
	entry_t entry_rd_q;

	logic                match, tbl_full, chain_end, ins;
	link_t               new_next, follow, follow_m1, link_m1;
	logic                head_we, entry_re;
	bucket_t             head_waddr;
	link_t               head_wdata;
	logic [ENTRY_W-1:0]  entry_raddr, entry_waddr;
	entry_t              entry_wdata;

	// walk control and memory port drive
	always_comb begin
		match     = (entry_rd_q.key == key_q);
		tbl_full  = (count_q == LINK_W'(MAX_ENTRIES));
		chain_end = ((state_q == ST_HEAD) && (head_rd_q == '0))
			|| ((state_q == ST_WALK) && !match && (entry_rd_q.next == '0));
		ins       = chain_end && !tbl_full;
		new_next  = (state_q == ST_HEAD) ? head_rd_q : head_link_q;
		follow    = (state_q == ST_HEAD) ? head_rd_q : entry_rd_q.next;
		follow_m1 = follow - LINK_W'(1);
		link_m1   = link_q - LINK_W'(1);
		entry_re  = ((state_q == ST_HEAD) && (head_rd_q != '0))
			|| ((state_q == ST_WALK) && !match && (entry_rd_q.next != '0));
		entry_raddr = follow_m1[ENTRY_W-1:0];
		entry_waddr = count_q[ENTRY_W-1:0];
		entry_wdata = '{key: key_q, next: new_next};
		pop         = (state_q == ST_IDLE) && !qstat.empty;
		head_we     = (state_q == ST_CLEAR) || ins;
		head_waddr  = (state_q == ST_CLEAR) ? clr_q : bucket_q;
		head_wdata  = (state_q == ST_CLEAR) ? '0 : count_q + LINK_W'(1);
	end

	// bucket head memory
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (pop) begin
			head_rd_q <= head_mem[head_item.bucket];
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (ins) begin
			entry_mem[entry_waddr] <= entry_wdata;
		end
		if (entry_re) begin
			entry_rd_q <= entry_mem[entry_raddr];
		end
	end

	// sequencer, table state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken while no new one is being loaded
			if (out_valid_q && result_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BUCKET_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!qstat.empty) begin
						key_q    <= head_item.key;
						bucket_q <= head_item.bucket;
						state_q  <= ST_HEAD;
					end
				end
				ST_HEAD, ST_WALK: begin
					if (state_q == ST_HEAD) begin
						head_link_q <= head_rd_q;
					end
					if ((state_q == ST_WALK) && match) begin
						res_idx_q  <= INDEX_W'(link_m1[ENTRY_W-1:0]);
						res_new_q  <= 1'b0;
						res_full_q <= 1'b0;
						state_q    <= ST_DONE;
					end else if (chain_end) begin
						if (tbl_full) begin
							res_idx_q  <= '0;
							res_new_q  <= 1'b0;
							res_full_q <= 1'b1;
						end else begin
							res_idx_q  <= INDEX_W'(count_q[ENTRY_W-1:0]);
							res_new_q  <= 1'b1;
							res_full_q <= 1'b0;
							count_q    <= count_q + 1'b1;
						end
						state_q <= ST_DONE;
					end else begin
						link_q  <= follow;
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result_ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= res_idx_q;
						out_new_q   <= res_new_q;
						out_full_q  <= res_full_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign unique_index = out_idx_q;
	assign is_new       = out_new_q;
	assign table_full   = out_full_q;

	`VDHT_ASSERT_NXT(a_count_step, ins, count_q == $past(count_q) + 1'b1, "entry count slip")
	`VDHT_ASSERT_IMP(a_clear_no_pop, state_q == ST_CLEAR, !pop, "pop during clear")
	`VDHT_ASSERT_IMP(a_result_excl, out_valid_q, !(out_new_q && out_full_q), "new and full")

endmodule
